@@ sv/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window minimum unit
// Sample width, default window depth, register map and the scan token type.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int DATA_W         = 32;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int WSIZE_W        = 7;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	// register index, taken from paddr bit 2
	localparam logic REG_WINDOW_SIZE = 1'b0;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd1;

	// partial minimum travelling down the cell row
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] min;
	} scan_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

@@ sv/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell: one cell of the window row
// Holds one sample of the window, shifts it to its neighbor on each new
// transfer and, inside the window, folds it into the passing partial minimum.
// ----------------------------------------------------------------------------
module swm_cell
	import swm_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic              en,
	input  logic [CW-1:0]     win,
	input  logic [DATA_W-1:0] sample_in,
	output logic [DATA_W-1:0] sample_out,
	input  scan_t             scan_in,
	output scan_t             scan_out
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [DATA_W-1:0] sample_q;
	logic              vld_q;
	logic [DATA_W-1:0] min_q;
	logic              active;
	logic              take;

	assign active = IDX_C < win;
	assign take   = active && ($signed(sample_q) < $signed(scan_in.min));

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= scan_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			min_q <= take ? sample_q : scan_in.min;
		end
	end

	assign sample_out   = sample_q;
	assign scan_out.vld = vld_q;
	assign scan_out.min = min_q;

endmodule

@@ sv/sliding_window_minimum_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_minimum_unit: minimum over the last window_size samples
// Path: a scan token is registered in inject_q, walks the row of WINDOW_MAX
// cells and is captured in the output register; output stalls hold the row.
// Flow: a sample that completes the window holds s_tready low until its
// result is captured; while the window fills, one sample per cycle is taken.
// Reset: window_size to 1, fill count and scan state cleared.
// ----------------------------------------------------------------------------
module sliding_window_minimum_unit
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample transfer in
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DATA_W-1:0]  s_tdata,  // [31:0] sample
	// window minimum transfer out
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DATA_W-1:0]  m_tdata,  // [31:0] window_min
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam logic [CW-1:0] MAX_C = CW'(WINDOW_MAX);

	logic [WSIZE_W-1:0] wsize_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      fill_next;
	logic [CW-1:0]      win;
	logic [31:0]        wsize_ext;
	state_t             state_q;
	state_t             state_next;
	scan_t              inject_q;
	logic               accept;
	logic               done;
	logic               capture;
	logic               en;
	logic               out_vld_q;
	logic [DATA_W-1:0]  out_data_q;

	logic [DATA_W-1:0] sample_chain [0:WINDOW_MAX];
	scan_t             scan_chain   [0:WINDOW_MAX];

	// configuration port
	assign pready = 1'b1;
	assign prdata = PDATA_W'(wsize_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= WSIZE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE) begin
			wsize_q <= pwdata[WSIZE_W-1:0];
		end
	end

	// effective window
	assign wsize_ext = 32'(wsize_q);
	always_comb begin
		if (wsize_ext == 32'd0) begin
			win = CW'(1);
		end else if (wsize_ext > 32'(WINDOW_MAX)) begin
			win = MAX_C;
		end else begin
			win = CW'(wsize_ext);
		end
	end

	assign accept    = s_tvalid && s_tready;
	assign fill_next = (fill_q < MAX_C) ? fill_q + CW'(1) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	// scan control
	assign done    = scan_chain[WINDOW_MAX].vld;
	assign capture = done && (!out_vld_q || m_tready);
	assign en      = !(done && !capture);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && fill_next >= win) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (capture) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: s_tready = 1'b0;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inject_q.vld <= 1'b0;
			inject_q.min <= {1'b0, {(DATA_W-1){1'b1}}};
		end else if (en) begin
			inject_q.vld <= accept && (fill_next >= win);
			inject_q.min <= {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	// cell row
	assign sample_chain[0] = s_tdata;
	assign scan_chain[0]   = inject_q;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (accept),
			.en         (en),
			.win        (win),
			.sample_in  (sample_chain[i]),
			.sample_out (sample_chain[i+1]),
			.scan_in    (scan_chain[i]),
			.scan_out   (scan_chain[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (capture) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_data_q <= scan_chain[WINDOW_MAX].min;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// checks
	a_no_token_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !done)
		else $error("scan token at row end while idle");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fill_next >= win) |=> (state_q == ST_SCAN && inject_q.vld))
		else $error("full window transfer did not start a scan");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_vld_q && !m_tready) |=> (done && $stable(scan_chain[WINDOW_MAX].min)))
		else $error("finished minimum lost while output stalled");

endmodule
